/* rtl/lce_pkg.sv */
// shared types and constants for the lru cache with expiry
`default_nettype none
package lce_pkg;
    localparam int ENTRIES_DEF   = 8;
    localparam int KEY_BITS_DEF  = 32;
    localparam int TIME_BITS_DEF = 32;

    localparam logic [1:0] KIND_GET  = 2'd0;
    localparam logic [1:0] KIND_PUT  = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // command from controller to datapath
    typedef struct packed {
        logic load;   // capture the incoming word
        logic exec;   // apply the operation to the store
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_sts;
endpackage
`default_nettype wire

/* rtl/lce_ctrl.sv */
// controller: accepts a word, runs the store update, holds the result
`default_nettype none
module lce_ctrl (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output lce_pkg::t_cmd o_cmd
);
    import lce_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] r_state, n_state;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    ap_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and valid together");
    ap_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec) else $error("exec must follow load");
    ap_exec_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_out_valid) else $error("result must follow exec");
endmodule
`default_nettype wire

/* rtl/lce_dp.sv */
// datapath: entry store, key compare, recency ranks, expiry sweep
`default_nettype none
module lce_dp #(
    parameter int ENTRIES   = lce_pkg::ENTRIES_DEF,
    parameter int KEY_BITS  = lce_pkg::KEY_BITS_DEF,
    parameter int TIME_BITS = lce_pkg::TIME_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  lce_pkg::t_cmd i_cmd,
    input  wire          i_cfg_we,
    input  wire  [3:0]   i_cfg_cap,
    input  wire  [1:0]   i_kind,
    input  wire  [31:0]  i_key,
    input  wire  [31:0]  i_put_value,
    input  wire  [15:0]  i_expire_after,
    output logic         o_hit,
    output logic [31:0]  o_read_value,
    output logic         o_evicted,
    output logic [31:0]  o_evicted_key,
    output logic [3:0]   o_expired_count
);
    import lce_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    logic [3:0]          r_cap;
    logic [ENTRIES-1:0]  r_valid;
    logic [KEY_BITS-1:0] r_ekey  [ENTRIES];
    logic [31:0]         r_edata [ENTRIES];
    logic [TIME_BITS-1:0] r_eexp [ENTRIES];
    logic [ENTRIES-1:0]  r_ehas;
    logic [IW-1:0]       r_rank  [ENTRIES];
    logic [TIME_BITS-1:0] r_now;
    logic [CW-1:0]       r_count;

    // captured word and stage-one results
    logic [1:0]          r_kind;
    logic [KEY_BITS-1:0] r_key;
    logic [31:0]         r_val;
    logic [15:0]         r_life;
    logic [ENTRIES-1:0]  r_match;
    logic [TIME_BITS-1:0] r_exp_new;

    logic [ENTRIES-1:0]  n_match;
    logic [TIME_BITS-1:0] n_exp_new;
    logic [TIME_BITS-1:0] w_room;
    logic [TIME_BITS-1:0] w_life_ext;

    assign w_life_ext = TIME_BITS'(i_expire_after);
    assign w_room     = TMAX - r_now;
    assign n_exp_new  = (w_life_ext > w_room) ? TMAX : r_now + w_life_ext;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++)
            n_match[i] = r_valid[i] && (r_ekey[i] == KEY_BITS'(i_key));
    end

    // effective capacity
    logic [CW-1:0] w_cap;
    always_comb begin
        if (r_cap == 4'd0)                  w_cap = CW'(1);
        else if (32'(r_cap) > ENTRIES)      w_cap = CW'(ENTRIES);
        else                                w_cap = CW'(r_cap);
    end

    // stage two combinational evaluation
    logic             w_hit;
    logic [IW-1:0]    w_hidx;
    logic [IW-1:0]    w_hrank;
    logic             w_full;
    logic             w_victim_ok;
    logic [IW-1:0]    w_vidx;
    logic             w_free_ok;
    logic [IW-1:0]    w_fidx;
    logic [ENTRIES-1:0] w_exp_rm;
    logic [TIME_BITS-1:0] w_now_tick;

    assign w_now_tick = (r_now == TMAX) ? r_now : r_now + 1'b1;

    always_comb begin
        w_hit = 1'b0; w_hidx = '0;
        w_victim_ok = 1'b0; w_vidx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                w_hit = 1'b1; w_hidx = IW'(i);
            end
            if (r_valid[i] && CW'(r_rank[i]) == r_count - 1'b1) begin
                w_victim_ok = 1'b1; w_vidx = IW'(i);
            end
        end
        w_hrank = r_rank[w_hidx];
        w_full  = (r_count >= w_cap) && (r_count != '0);
    end

    // after optional eviction, first free slot
    logic [ENTRIES-1:0] w_valid_ev;
    always_comb begin
        w_valid_ev = r_valid;
        if (w_full && w_victim_ok) w_valid_ev[w_vidx] = 1'b0;
        w_free_ok = 1'b0; w_fidx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
            if (!w_valid_ev[i]) begin
                w_free_ok = 1'b1; w_fidx = IW'(i);
            end
        for (int i = 0; i < ENTRIES; i++)
            w_exp_rm[i] = r_valid[i] && r_ehas[i] && (r_eexp[i] <= w_now_tick);
    end

    // new ranks; on a tick each entry counts how many removed entries were younger
    logic [IW-1:0]      n_rank  [ENTRIES];
    logic [ENTRIES-1:0] n_valid;
    logic [CW-1:0]      w_rmcnt;
    always_comb begin
        logic [CW-1:0] dec;
        dec     = '0;
        n_valid = r_valid;
        w_rmcnt = '0;
        for (int i = 0; i < ENTRIES; i++) n_rank[i] = r_rank[i];
        unique case (r_kind)
            KIND_GET: begin
                if (w_hit)
                    for (int i = 0; i < ENTRIES; i++)
                        if (IW'(i) == w_hidx)                        n_rank[i] = '0;
                        else if (r_valid[i] && r_rank[i] < w_hrank)  n_rank[i] = r_rank[i] + 1'b1;
            end
            KIND_PUT: begin
                if (w_hit) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (IW'(i) == w_hidx)                        n_rank[i] = '0;
                        else if (r_valid[i] && r_rank[i] < w_hrank)  n_rank[i] = r_rank[i] + 1'b1;
                end else begin
                    // victim has the oldest rank, so survivors keep theirs before the shift
                    n_valid = w_valid_ev;
                    if (w_free_ok) begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (w_valid_ev[i]) n_rank[i] = r_rank[i] + 1'b1;
                        n_valid[w_fidx] = 1'b1;
                        n_rank[w_fidx]  = '0;
                    end
                end
            end
            KIND_TICK: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    dec = '0;
                    for (int j = 0; j < ENTRIES; j++)
                        if (w_exp_rm[j] && r_rank[j] < r_rank[i]) dec = dec + 1'b1;
                    if (r_valid[i] && !w_exp_rm[i]) n_rank[i] = r_rank[i] - IW'(dec);
                    if (w_exp_rm[i]) begin
                        n_valid[i] = 1'b0;
                        w_rmcnt    = w_rmcnt + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_kind;
            r_key     <= KEY_BITS'(i_key);
            r_val     <= i_put_value;
            r_life    <= i_expire_after;
            r_match   <= n_match;
            r_exp_new <= n_exp_new;
        end
        if (i_cmd.exec) begin
            if (r_kind == KIND_PUT) begin
                if (w_hit) begin
                    r_edata[w_hidx] <= r_val;
                    if (r_life != 16'd0) begin
                        r_eexp[w_hidx] <= r_exp_new;
                        r_ehas[w_hidx] <= 1'b1;
                    end
                end else if (w_free_ok) begin
                    r_ekey[w_fidx]  <= r_key;
                    r_edata[w_fidx] <= r_val;
                    r_eexp[w_fidx]  <= r_exp_new;
                    r_ehas[w_fidx]  <= (r_life != 16'd0);
                end
            end
            o_hit           <= w_hit && (r_kind == KIND_GET || r_kind == KIND_PUT);
            o_read_value    <= (r_kind == KIND_GET) ? (w_hit ? r_edata[w_hidx] : '1) : '0;
            o_evicted       <= (r_kind == KIND_PUT) && !w_hit && w_full && w_victim_ok;
            o_evicted_key   <= ((r_kind == KIND_PUT) && !w_hit && w_full && w_victim_ok)
                               ? 32'(r_ekey[w_vidx]) : '0;
            o_expired_count <= (r_kind == KIND_TICK)
                               ? ((32'(w_rmcnt) > 15) ? 4'd15 : 4'(w_rmcnt)) : 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= 4'(ENTRIES > 15 ? 15 : ENTRIES);
            r_valid <= '0;
            r_now   <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) r_rank[i] <= '0;
        end else if (i_cfg_we) begin
            r_cap   <= i_cfg_cap;
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) r_rank[i] <= '0;
        end else if (i_cmd.exec) begin
            r_valid <= n_valid;
            for (int i = 0; i < ENTRIES; i++) r_rank[i] <= n_rank[i];
            if (r_kind == KIND_TICK) begin
                r_now   <= w_now_tick;
                r_count <= r_count - w_rmcnt;
            end else if (r_kind == KIND_PUT && !w_hit) begin
                r_count <= r_count - CW'(w_full && w_victim_ok) + CW'(w_free_ok);
            end
        end
    end

    ap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) == $countones(r_valid)) else $error("count and valid bits disagree");
    ap_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> $onehot0(r_match)) else $error("key present in two entries");
    ap_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES)) else $error("count above entry count");
endmodule
`default_nettype wire

/* rtl/lru_cache_with_expiry_core.sv */
// top level: lru cache with per-entry expiry
// a word is captured when accepted in idle, applied to the store in the execute state, then held in the output state
// a new word is accepted only in idle, after the previous result has been taken by the consumer
// the key compare runs in the accept cycle, rank update and expiry sweep in the execute cycle
// reset (i_rst_n low, synchronous) empties the store, zeroes time and sets capacity to entries (at most 15)
// a capacity write also empties the store but keeps time
`default_nettype none
module lru_cache_with_expiry_core #(
    parameter int ENTRIES   = lce_pkg::ENTRIES_DEF,
    parameter int KEY_BITS  = lce_pkg::KEY_BITS_DEF,
    parameter int TIME_BITS = lce_pkg::TIME_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [3:0]  i_cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [79:0] s_axis_tdata,  // key[31:0], put_value[63:32], expire_after[79:64]
    input  wire  [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [71:0] m_axis_tdata   // hit[0], read_value[32:1], evicted[33],
                                       // evicted_key[65:34], expired_count[69:66], zero[71:70]
);
    import lce_pkg::*;

    t_cmd        w_cmd;
    logic        w_hit, w_ev;
    logic [31:0] w_rv, w_evk;
    logic [3:0]  w_exc;

    lce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    lce_dp #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .TIME_BITS(TIME_BITS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_cap       (i_cfg_wdata),
        .i_kind          (s_axis_tuser),
        .i_key           (s_axis_tdata[31:0]),
        .i_put_value     (s_axis_tdata[63:32]),
        .i_expire_after  (s_axis_tdata[79:64]),
        .o_hit           (w_hit),
        .o_read_value    (w_rv),
        .o_evicted       (w_ev),
        .o_evicted_key   (w_evk),
        .o_expired_count (w_exc)
    );

    assign m_axis_tdata = {2'b00, w_exc, w_evk, w_ev, w_rv, w_hit};
endmodule
`default_nettype wire
